FILE: sv/sct_pkg.sv
// Shared types, codes and sizes of the sparse CSC transpose block.
// Used by sct_ctrl, sct_datapath and sparse_csc_transpose; depends on nothing.
`default_nettype none
package sct_pkg;

  localparam int MAX_NNZ    = 1024;
  localparam int NNZ_AW     = 10;
  localparam int MAX_DIM    = 256;
  localparam int DIM_AW     = 8;
  localparam int VALUE_BITS = 64;
  localparam int CNT_W      = 11;
  localparam int REG_W      = 9;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PTR   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ORDER   = 2'd3
  } status_t;

  localparam logic [2:0] ADDR_NUM_ROWS = 3'd0;
  localparam logic [2:0] ADDR_NUM_COLS = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic set_err;
    logic ld_rd;
    logic ld_wr;
    logic tr_start;
    logic pf_rd;
    logic pf_wr;
    logic sc_rd_in;
    logic sc_rd_cnt;
    logic sc_wr;
    logic tr_finish;
    logic f_rd;
    logic f_out;
  } sct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic done;
    logic load_ok;
    logic pf_last;
    logic sc_more;
    logic out_free;
  } sct_stat_t;

  function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] r);
    return (r > REG_W'(MAX_DIM)) ? REG_W'(MAX_DIM) : r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sct_ctrl.sv
// Controller state machine of the sparse CSC transpose block.
// Depends on sct_pkg; drives sct_datapath through sct_cmd_t.
`default_nettype none
module sct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sct_pkg::sct_stat_t stat,
  output sct_pkg::sct_cmd_t       cmd_o
);
  import sct_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_DECODE    = 13'h0002,
    S_LD_RD     = 13'h0004,
    S_LD_WR     = 13'h0008,
    S_PF_RD     = 13'h0010,
    S_PF_WR     = 13'h0020,
    S_SC_CHK    = 13'h0040,
    S_SC_RD_IN  = 13'h0080,
    S_SC_RD_CNT = 13'h0100,
    S_SC_WR     = 13'h0200,
    S_F_RD      = 13'h0400,
    S_F_OUT     = 13'h0800,
    S_SPARE     = 13'h1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_o      = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (stat.cmd)
          CMD_CLEAR: cmd_o.clear = 1'b1;
          CMD_LOAD: begin
            if (!stat.done) begin
              if (stat.load_ok) state_next = S_LD_RD;
              else              cmd_o.set_err = 1'b1;
            end
          end
          CMD_FETCH: begin
            if (stat.done) begin
              state_next = S_F_RD;
            end else begin
              cmd_o.tr_start = 1'b1;
              state_next     = S_PF_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LD_RD: begin
        cmd_o.ld_rd = 1'b1;
        state_next  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd_o.ld_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_PF_RD: begin
        cmd_o.pf_rd = 1'b1;
        state_next  = S_PF_WR;
      end
      S_PF_WR: begin
        cmd_o.pf_wr = 1'b1;
        state_next  = stat.pf_last ? S_SC_CHK : S_PF_RD;
      end
      S_SC_CHK: begin
        if (stat.sc_more) begin
          state_next = S_SC_RD_IN;
        end else begin
          cmd_o.tr_finish = 1'b1;
          state_next      = S_F_RD;
        end
      end
      S_SC_RD_IN: begin
        cmd_o.sc_rd_in = 1'b1;
        state_next     = S_SC_RD_CNT;
      end
      S_SC_RD_CNT: begin
        cmd_o.sc_rd_cnt = 1'b1;
        state_next      = S_SC_WR;
      end
      S_SC_WR: begin
        cmd_o.sc_wr = 1'b1;
        state_next  = S_SC_CHK;
      end
      S_F_RD: begin
        cmd_o.f_rd = 1'b1;
        state_next = S_F_OUT;
      end
      S_F_OUT: begin
        if (stat.out_free) begin
          cmd_o.f_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/sct_datapath.sv
// Datapath of the sparse CSC transpose block: entry, count and pointer
// memories, counters, error flag and the output register. Depends on sct_pkg.
`default_nettype none
module sct_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sct_pkg::sct_cmd_t                 cmd_i,
  output sct_pkg::sct_stat_t                     stat,
  input  wire logic [sct_pkg::REG_W-1:0]         num_rows,
  input  wire logic [sct_pkg::REG_W-1:0]         num_cols,
  input  wire logic [1:0]                        cmd,
  input  wire logic [sct_pkg::DIM_AW-1:0]        row_index,
  input  wire logic [sct_pkg::DIM_AW-1:0]        col_index,
  input  wire logic [sct_pkg::VALUE_BITS-1:0]    entry_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             word_kind,
  output logic [sct_pkg::CNT_W-1:0]              position,
  output logic [sct_pkg::DIM_AW-1:0]             out_row,
  output logic [sct_pkg::VALUE_BITS-1:0]         out_value,
  output logic                                   is_last,
  output logic [1:0]                             status
);
  import sct_pkg::*;

  localparam int IN_W  = 2 * DIM_AW + VALUE_BITS;
  localparam int OUT_W = DIM_AW + VALUE_BITS;

  // memories
  logic [CNT_W-1:0] cnt_mem [MAX_DIM];
  logic [CNT_W-1:0] ptr_mem [MAX_DIM];
  logic [IN_W-1:0]  in_mem  [MAX_NNZ];
  logic [OUT_W-1:0] out_mem [MAX_NNZ];
  logic [MAX_DIM-1:0] cnt_valid;

  logic [CNT_W-1:0] cnt_rd;
  logic             cnt_rd_valid;
  logic [CNT_W-1:0] ptr_rd;
  logic [IN_W-1:0]  in_rd;
  logic [OUT_W-1:0] out_rd;

  // captured item
  cmd_t                  cmd_q;
  logic [DIM_AW-1:0]     row_q;
  logic [DIM_AW-1:0]     col_q;
  logic [VALUE_BITS-1:0] val_q;

  // control registers
  logic [CNT_W-1:0]  entry_count;
  logic [DIM_AW-1:0] prev_col;
  logic              done;
  logic [CNT_W-1:0]  cursor;
  logic [1:0]        error_code;
  logic [DIM_AW-1:0] r_cnt;
  logic [CNT_W-1:0]  sum;
  logic [CNT_W-1:0]  p_cnt;

  logic [CNT_W-1:0]  cnt_val;
  logic [1:0]        load_code;
  logic [REG_W-1:0]  m_dim;
  logic [REG_W-1:0]  n_dim;
  logic              cnt_rd_en;
  logic [DIM_AW-1:0] cnt_rd_addr;
  logic              cnt_wr_en;
  logic [DIM_AW-1:0] cnt_wr_addr;
  logic [CNT_W-1:0]  cnt_wr_data;
  logic [DIM_AW-1:0] in_rd_row;
  logic [DIM_AW-1:0] in_rd_col;
  logic [VALUE_BITS-1:0] in_rd_val;
  logic [CNT_W-1:0]  s_idx;
  logic [CNT_W:0]    total;

  assign m_dim   = eff_dim(num_rows);
  assign n_dim   = eff_dim(num_cols);
  assign cnt_val = cnt_rd_valid ? cnt_rd : '0;
  assign {in_rd_row, in_rd_col, in_rd_val} = in_rd;
  assign s_idx   = cursor - CNT_W'(m_dim) - CNT_W'(1);
  assign total   = (CNT_W+1)'(m_dim) + (CNT_W+1)'(1) + (CNT_W+1)'(entry_count);

  always_comb begin
    if ({1'b0, row_q} >= m_dim || {1'b0, col_q} >= n_dim) load_code = ST_RANGE;
    else if (col_q < prev_col)                           load_code = ST_ORDER;
    else if (entry_count >= CNT_W'(MAX_NNZ))             load_code = ST_FULL;
    else                                                 load_code = ST_OK;
  end

  always_comb begin
    stat.cmd      = cmd_q;
    stat.done     = done;
    stat.load_ok  = (load_code == ST_OK);
    stat.pf_last  = (r_cnt == DIM_AW'(MAX_DIM - 1));
    stat.sc_more  = (p_cnt < entry_count);
    stat.out_free = !out_valid || out_ready;
  end

  // count memory port selection
  always_comb begin
    cnt_rd_en   = cmd_i.ld_rd || cmd_i.pf_rd || cmd_i.sc_rd_cnt;
    cnt_rd_addr = cmd_i.ld_rd ? row_q : (cmd_i.pf_rd ? r_cnt : in_rd_row);
    cnt_wr_en   = cmd_i.ld_wr || cmd_i.pf_wr || cmd_i.sc_wr;
    cnt_wr_addr = row_q;
    cnt_wr_data = cnt_val + CNT_W'(1);
    if (cmd_i.pf_wr) begin
      cnt_wr_addr = r_cnt;
      cnt_wr_data = sum;
    end else if (cmd_i.sc_wr) begin
      cnt_wr_addr = in_rd_row;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cnt_rd_en) cnt_rd <= cnt_mem[cnt_rd_addr];
    if (cnt_wr_en) cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    if (cmd_i.pf_wr) ptr_mem[r_cnt] <= sum;
    if (cmd_i.f_rd)  ptr_rd <= ptr_mem[cursor[DIM_AW-1:0]];
    if (cmd_i.ld_wr) in_mem[entry_count[NNZ_AW-1:0]] <= {row_q, col_q, val_q};
    if (cmd_i.sc_rd_in) in_rd <= in_mem[p_cnt[NNZ_AW-1:0]];
    if (cmd_i.sc_wr && !cnt_val[CNT_W-1])
      out_mem[cnt_val[NNZ_AW-1:0]] <= {in_rd_col, in_rd_val};
    if (cmd_i.f_rd) out_rd <= out_mem[s_idx[NNZ_AW-1:0]];
  end

  // captured item and walk counters
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_q <= cmd_t'(cmd);
      row_q <= row_index;
      col_q <= col_index;
      val_q <= entry_value;
    end
    if (cmd_i.tr_start) begin
      r_cnt <= '0;
      sum   <= '0;
      p_cnt <= '0;
    end
    if (cmd_i.pf_wr) begin
      r_cnt <= r_cnt + DIM_AW'(1);
      sum   <= sum + cnt_val;
    end
    if (cmd_i.sc_wr) p_cnt <= p_cnt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_rd_valid <= 1'b0;
      cnt_valid    <= '0;
      entry_count  <= '0;
      prev_col     <= '0;
      done         <= 1'b0;
      cursor       <= '0;
      error_code   <= ST_OK;
    end else begin
      if (cnt_rd_en) cnt_rd_valid <= cnt_valid[cnt_rd_addr];
      if (cnt_wr_en) cnt_valid[cnt_wr_addr] <= 1'b1;
      if (cmd_i.clear) begin
        cnt_valid   <= '0;
        entry_count <= '0;
        prev_col    <= '0;
        done        <= 1'b0;
        cursor      <= '0;
        error_code  <= ST_OK;
      end
      if (cmd_i.set_err && error_code == ST_OK) error_code <= load_code;
      if (cmd_i.ld_wr) begin
        prev_col    <= col_q;
        entry_count <= entry_count + CNT_W'(1);
      end
      if (cmd_i.tr_finish) done <= 1'b1;
      if (cmd_i.f_out && ({1'b0, cursor} < total)) cursor <= cursor + CNT_W'(1);
    end
  end

  // output register: a fetch result waits here until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.f_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.f_out) begin
      status <= error_code;
      if (cursor <= CNT_W'(m_dim)) begin
        word_kind <= KIND_PTR;
        position  <= (cursor == CNT_W'(m_dim)) ? entry_count : ptr_rd;
        out_row   <= '0;
        out_value <= '0;
        is_last   <= (cursor == CNT_W'(m_dim)) && (entry_count == '0);
      end else if ({1'b0, cursor} < total) begin
        word_kind <= KIND_ENTRY;
        position  <= s_idx;
        out_row   <= out_rd[OUT_W-1 -: DIM_AW];
        out_value <= out_rd[VALUE_BITS-1:0];
        is_last   <= (s_idx + CNT_W'(1) == entry_count);
      end else begin
        word_kind <= KIND_END;
        position  <= '0;
        out_row   <= '0;
        out_value <= '0;
        is_last   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/sparse_csc_transpose.sv
// Items are handled one at a time: in_ready is high only in idle, and a fetch
// may also wait for the output register to be free. The first fetch also runs
// the transpose once: a prefix sum over all MAX_DIM rows (one count-memory read
// and write per row), then a scatter that reads each loaded entry and its row
// count and writes the entry to its transposed place. Reset (synchronous,
// active high) clears config, counters, status and count valid bits.
// Top level of the sparse CSC transpose block; instantiates sct_ctrl and
// sct_datapath and holds the APB configuration registers. Depends on sct_pkg.
`default_nettype none
module sparse_csc_transpose (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // input words
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     cmd,
  input  wire logic [sct_pkg::DIM_AW-1:0]     row_index,
  input  wire logic [sct_pkg::DIM_AW-1:0]     col_index,
  input  wire logic [sct_pkg::VALUE_BITS-1:0] entry_value,
  // result words
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          word_kind,
  output logic [sct_pkg::CNT_W-1:0]           position,
  output logic [sct_pkg::DIM_AW-1:0]          out_row,
  output logic [sct_pkg::VALUE_BITS-1:0]      out_value,
  output logic                                is_last,
  output logic [1:0]                          status
);
  import sct_pkg::*;

  logic [REG_W-1:0] num_rows;
  logic [REG_W-1:0] num_cols;
  sct_cmd_t         ctl_cmd;
  sct_stat_t        dp_stat;
  logic             cfg_wr;

  // APB: no wait states; the register is chosen by address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= '0;
      num_cols <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_NUM_COLS[2]) num_cols <= pwdata[REG_W-1:0];
      else                              num_rows <= pwdata[REG_W-1:0];
    end
  end

  // read back the addressed register
  always_comb begin
    if (paddr[2] == ADDR_NUM_COLS[2]) prdata = {{(32-REG_W){1'b0}}, num_cols};
    else                              prdata = {{(32-REG_W){1'b0}}, num_rows};
  end

  // sequence loads, the one-time transpose and fetches
  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd_o    (ctl_cmd)
  );

  // memories, counters and the output register
  sct_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_i       (ctl_cmd),
    .stat        (dp_stat),
    .num_rows    (num_rows),
    .num_cols    (num_cols),
    .cmd         (cmd),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .word_kind   (word_kind),
    .position    (position),
    .out_row     (out_row),
    .out_value   (out_value),
    .is_last     (is_last),
    .status      (status)
  );

endmodule
`default_nettype wire
